/* rtl/cfir_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cfir_pkg;

  localparam int TAP_REGS         = 8;
  localparam int TAP_IDX_W        = $clog2(TAP_REGS);
  localparam int TAP_W            = 16;
  localparam int FRAC_SHIFT       = 15;
  localparam int CFG_INDEX_W      = 8;
  localparam int PIPE_STAGES      = 4;
  localparam int DEF_NUM_TAPS     = 8;
  localparam int DEF_SAMPLE_WIDTH = 16;

  typedef struct packed {
    logic adv;
    logic take;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

/* rtl/cfir_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfir_cell #(
  parameter int SAMPLE_WIDTH = cfir_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire                                            clk,
  input  wire                                            rst,
  input  cfir_pkg::pipe_ctrl_t                           ctrl,
  input  wire signed [cfir_pkg::TAP_W-1:0]               tap,
  input  wire signed [SAMPLE_WIDTH-1:0]                  win_re,
  input  wire signed [SAMPLE_WIDTH-1:0]                  win_im,
  input  wire signed [SAMPLE_WIDTH-1:0]                  load_re,
  input  wire signed [SAMPLE_WIDTH-1:0]                  load_im,
  output logic signed [SAMPLE_WIDTH-1:0]                 held_re,
  output logic signed [SAMPLE_WIDTH-1:0]                 held_im,
  output logic signed [SAMPLE_WIDTH+cfir_pkg::TAP_W-1:0] prod_re,
  output logic signed [SAMPLE_WIDTH+cfir_pkg::TAP_W-1:0] prod_im
);
  import cfir_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + TAP_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_re <= '0;
      held_im <= '0;
    end else if (ctrl.take) begin
      held_re <= load_re;
      held_im <= load_im;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      prod_re <= PROD_W'(tap) * PROD_W'(win_re);
      prod_im <= PROD_W'(tap) * PROD_W'(win_im);
    end
  end

endmodule

`default_nettype wire

/* rtl/cfir_sum.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfir_sum #(
  parameter int SAMPLE_WIDTH = cfir_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire                                            clk,
  input  wire                                            adv,
  input  wire signed [SAMPLE_WIDTH+cfir_pkg::TAP_W-1:0]  prod [cfir_pkg::TAP_REGS],
  output logic signed [SAMPLE_WIDTH-1:0]                 res
);
  import cfir_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + TAP_W;
  localparam int ACC_W  = PROD_W + 4;
  localparam int QW     = ACC_W - FRAC_SHIFT;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [QW-1:0] Q_HI =
    {{(QW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_LO =
    {{(QW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [PROD_W:0]   lvl1 [TAP_REGS/2];
  logic signed [PROD_W+1:0] lvl2 [TAP_REGS/4];
  logic signed [ACC_W-1:0]  acc;
  logic signed [QW-1:0]     q;
  logic signed [SAMPLE_WIDTH-1:0] res_next;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < TAP_REGS / 2; i++) begin
        lvl1[i] <= (PROD_W+1)'(prod[2*i]) + (PROD_W+1)'(prod[2*i+1]);
      end
      for (int i = 0; i < TAP_REGS / 4; i++) begin
        lvl2[i] <= (PROD_W+2)'(lvl1[2*i]) + (PROD_W+2)'(lvl1[2*i+1]);
      end
      res <= res_next;
    end
  end

  always_comb begin
    acc = ACC_W'(lvl2[0]) + ACC_W'(lvl2[1]) + RND;
    q   = acc[ACC_W-1:FRAC_SHIFT];
    if (q > Q_HI) begin
      res_next = Q_HI[SAMPLE_WIDTH-1:0];
    end else if (q < Q_LO) begin
      res_next = Q_LO[SAMPLE_WIDTH-1:0];
    end else begin
      res_next = q[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/complex_fir_real_taps.sv */
// Channel  Signals                         Direction  Width
// input    in_valid, in_ready              in         sample_re, sample_im: SAMPLE_WIDTH
// output   out_valid, out_ready            out        out_re, out_im: SAMPLE_WIDTH
// config   cfg_valid, cfg_ready            in         cfg_index: 8, cfg_data: 16
//
// One sample is taken in every cycle while the output is not held. A result passes through
// the cell products register, two adder tree levels and the final add with rounding and
// saturation into the output register.
// When the output is held, the whole pipeline holds and in_ready falls.
// Reset clears the taps, the history in the cells and all valid flags.
`timescale 1ns / 1ps
`default_nettype none

module complex_fir_real_taps #(
  parameter int NUM_TAPS     = cfir_pkg::DEF_NUM_TAPS,
  parameter int SAMPLE_WIDTH = cfir_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire signed [SAMPLE_WIDTH-1:0]        sample_re,
  input  wire signed [SAMPLE_WIDTH-1:0]        sample_im,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]       out_re,
  output logic signed [SAMPLE_WIDTH-1:0]       out_im,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [cfir_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire signed [cfir_pkg::TAP_W-1:0]     cfg_data
);
  import cfir_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + TAP_W;

  logic signed [TAP_W-1:0]        taps    [TAP_REGS];
  logic [PIPE_STAGES-1:0]         vld;
  pipe_ctrl_t                     ctrl;
  logic signed [SAMPLE_WIDTH-1:0] held_re [NUM_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] held_im [NUM_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] win_re  [NUM_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] win_im  [NUM_TAPS];
  logic signed [PROD_W-1:0]       prod_re [TAP_REGS];
  logic signed [PROD_W-1:0]       prod_im [TAP_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAP_REGS; i++) begin
        taps[i] <= '0;
      end
    end else if (cfg_valid && cfg_index < CFG_INDEX_W'(TAP_REGS)) begin
      taps[cfg_index[TAP_IDX_W-1:0]] <= cfg_data;
    end
  end

  assign ctrl.adv  = !vld[PIPE_STAGES-1] || out_ready;
  assign ctrl.take = ctrl.adv && in_valid;
  assign in_ready  = ctrl.adv;
  assign out_valid = vld[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctrl.adv) begin
      vld <= {vld[PIPE_STAGES-2:0], in_valid};
    end
  end

  // Cell k weights window position k; the last cell sees the incoming sample.
  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
    if (k == NUM_TAPS - 1) begin : g_last
      assign win_re[k] = sample_re;
      assign win_im[k] = sample_im;
    end else begin : g_hist
      assign win_re[k] = held_re[k];
      assign win_im[k] = held_im[k];
    end

    cfir_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .tap     (taps[k]),
      .win_re  (win_re[k]),
      .win_im  (win_im[k]),
      .load_re ((k == NUM_TAPS - 1) ? sample_re : win_re[(k + 1) % NUM_TAPS]),
      .load_im ((k == NUM_TAPS - 1) ? sample_im : win_im[(k + 1) % NUM_TAPS]),
      .held_re (held_re[k]),
      .held_im (held_im[k]),
      .prod_re (prod_re[k]),
      .prod_im (prod_im[k])
    );
  end

  for (genvar k = NUM_TAPS; k < TAP_REGS; k++) begin : g_pad
    assign prod_re[k] = '0;
    assign prod_im[k] = '0;
  end

  cfir_sum #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_sum_re (
    .clk  (clk),
    .adv  (ctrl.adv),
    .prod (prod_re),
    .res  (out_re)
  );

  cfir_sum #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_sum_im (
    .clk  (clk),
    .adv  (ctrl.adv),
    .prod (prod_im),
    .res  (out_im)
  );

endmodule

`default_nettype wire

/* rtl/cfir_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfir_checker #(
  parameter int NUM_TAPS     = cfir_pkg::DEF_NUM_TAPS,
  parameter int SAMPLE_WIDTH = cfir_pkg::DEF_SAMPLE_WIDTH
) (
  input wire                              clk,
  input wire                              rst,
  input wire                              in_valid,
  input wire                              in_ready,
  input wire [SAMPLE_WIDTH-1:0]           sample_re,
  input wire [SAMPLE_WIDTH-1:0]           sample_im,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire [SAMPLE_WIDTH-1:0]           out_re,
  input wire [SAMPLE_WIDTH-1:0]           out_im,
  input wire                              cfg_valid,
  input wire                              cfg_ready,
  input wire [cfir_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input wire [cfir_pkg::TAP_W-1:0]        cfg_data
);
  import cfir_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{sample_re, sample_im, cfg_valid, cfg_ready, cfg_index, cfg_data,
                       NUM_TAPS[0]};

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_re) && $stable(out_im))
    else $error("Stalled output transfer changed.");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("Input not ready while the pipeline can advance.");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("Result missing four cycles after an input transfer.");

endmodule

bind complex_fir_real_taps cfir_checker #(
  .NUM_TAPS     (NUM_TAPS),
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_cfir_checker (.*);

`default_nettype wire
